// File: rtl/sha256_stream_hasher_defines.svh
// Assertion macros used by the port checker file
`ifndef SHA256_STREAM_HASHER_DEFINES_SVH
`define SHA256_STREAM_HASHER_DEFINES_SVH
// implication checked on every rising clock edge outside reset
`define SHA_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// next-cycle implication checked outside reset
`define SHA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

// File: rtl/sha_pkg.sv
// Package with types, constants and functions of the SHA-256 stream hasher
package sha_pkg;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_valid;
      logic       end_of_message;
   } req_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last_word;
   } rsp_type;

   // classified front-end entry
   typedef struct packed {
      logic [7:0] data_byte;
      logic       has_byte;
      logic       is_end;
   } cmd_type;

   localparam int QueueDepthDefault = 4;
   localparam logic [7:0] PadByte = 8'h80;
   localparam logic [5:0] LenPos = 6'd56;

   typedef logic [31:0] word_type;
   typedef word_type [7:0] hash_type;

   localparam hash_type InitHash = '{
      32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
      32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667};

   localparam word_type [63:0] RoundK = '{
      32'hc67178f2, 32'hbef9a3f7, 32'ha4506ceb, 32'h90befffa,
      32'h8cc70208, 32'h84c87814, 32'h78a5636f, 32'h748f82ee,
      32'h682e6ff3, 32'h5b9cca4f, 32'h4ed8aa4a, 32'h391c0cb3,
      32'h34b0bcb5, 32'h2748774c, 32'h1e376c08, 32'h19a4c116,
      32'h106aa070, 32'hf40e3585, 32'hd6990624, 32'hd192e819,
      32'hc76c51a3, 32'hc24b8b70, 32'ha81a664b, 32'ha2bfe8a1,
      32'h92722c85, 32'h81c2c92e, 32'h766a0abb, 32'h650a7354,
      32'h53380d13, 32'h4d2c6dfc, 32'h2e1b2138, 32'h27b70a85,
      32'h14292967, 32'h06ca6351, 32'hd5a79147, 32'hc6e00bf3,
      32'hbf597fc7, 32'hb00327c8, 32'ha831c66d, 32'h983e5152,
      32'h76f988da, 32'h5cb0a9dc, 32'h4a7484aa, 32'h2de92c6f,
      32'h240ca1cc, 32'h0fc19dc6, 32'hefbe4786, 32'he49b69c1,
      32'hc19bf174, 32'h9bdc06a7, 32'h80deb1fe, 32'h72be5d74,
      32'h550c7dc3, 32'h243185be, 32'h12835b01, 32'hd807aa98,
      32'hab1c5ed5, 32'h923f82a4, 32'h59f111f1, 32'h3956c25b,
      32'he9b5dba5, 32'hb5c0fbcf, 32'h71374491, 32'h428a2f98};

   function automatic word_type rotr(input word_type x, input int n);
      rotr = (x >> n) | (x << (32 - n));
   endfunction

endpackage

// File: rtl/sha_front.sv
// Front end: takes transactions, classifies them and queues commands
module sha_front #(
   parameter int QueueDepth = sha_pkg::QueueDepthDefault
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  sha_pkg::req_type req_data,
   output logic             cmd_valid,
   input  logic             cmd_take,
   output sha_pkg::cmd_type cmd_data
);
   localparam int Aw = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;

   sha_pkg::cmd_type    queue_ff [QueueDepth];
   logic [Aw-1:0]       wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [Aw:0]         count_ff, count_in;
   logic                push, pop, useful;

   assign useful    = req_data.byte_valid | req_data.end_of_message;
   assign req_stall = (count_ff == (Aw+1)'(QueueDepth));
   assign push      = req_valid & ~req_stall & useful;
   assign cmd_valid = (count_ff != '0);
   assign pop       = cmd_valid & cmd_take;
   assign cmd_data  = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == Aw'(QueueDepth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == Aw'(QueueDepth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + (Aw+1)'(push) - (Aw+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= '{data_byte: req_data.data_byte,
                                  has_byte: req_data.byte_valid,
                                  is_end: req_data.end_of_message};
      end
   end
endmodule

// File: rtl/sha_back.sv
// Back end: block packing, padding, 64-round compression and digest output
module sha_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_valid,
   output logic             cmd_take,
   input  sha_pkg::cmd_type cmd_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output sha_pkg::rsp_type rsp_data
);
   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_ROUND = 5'b00010,
      ST_FIN   = 5'b00100,
      ST_PAD   = 5'b01000,
      ST_OUT   = 5'b10000
   } state_type;

   state_type           state_ff, state_in;
   sha_pkg::word_type   blk_ff [16];
   sha_pkg::hash_type   h_ff, v_ff;
   logic [5:0]          fill_ff, rnd_ff;
   logic [60:0]         len_ff;
   logic                pend_end_ff, second_ff, len_next_ff;
   logic [2:0]          out_idx_ff;
   logic                out_valid_ff;
   sha_pkg::word_type   out_word_ff;
   logic                out_last_ff;
   logic [2:0]          out_widx_ff;
   logic                out_load;

   sha_pkg::word_type   w_cur, w_new, t1, t2, s0, s1;
   logic [63:0]         bits;

   assign bits = {len_ff, 3'b000};
   assign w_cur = (rnd_ff < 6'd16) ? blk_ff[rnd_ff[3:0]] : w_new;

   always_comb begin
      s0 = sha_pkg::rotr(blk_ff[1], 7) ^ sha_pkg::rotr(blk_ff[1], 18) ^ (blk_ff[1] >> 3);
      s1 = sha_pkg::rotr(blk_ff[14], 17) ^ sha_pkg::rotr(blk_ff[14], 19)
           ^ (blk_ff[14] >> 10);
      w_new = s1 + blk_ff[9] + s0 + blk_ff[0];
      t1 = v_ff[7] + (sha_pkg::rotr(v_ff[4], 6) ^ sha_pkg::rotr(v_ff[4], 11)
           ^ sha_pkg::rotr(v_ff[4], 25)) + ((v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]))
           + sha_pkg::RoundK[rnd_ff] + w_cur;
      t2 = (sha_pkg::rotr(v_ff[0], 2) ^ sha_pkg::rotr(v_ff[0], 13)
           ^ sha_pkg::rotr(v_ff[0], 22)) + ((v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2])
           ^ (v_ff[1] & v_ff[2]));
   end

   assign cmd_take  = (state_ff == ST_IDLE) && cmd_valid;
   assign out_load  = (state_ff == ST_OUT) && (!out_valid_ff || !rsp_stall);
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = '{digest_word: out_word_ff, word_index: out_widx_ff,
                        last_word: out_last_ff};

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  ;
         ST_ROUND: if (rnd_ff == 6'd63) state_in = ST_FIN;
         ST_FIN:   ;
         ST_PAD:   ;
         ST_OUT:   ;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         h_ff         <= sha_pkg::InitHash;
         fill_ff      <= '0;
         len_ff       <= '0;
         pend_end_ff  <= 1'b0;
         second_ff    <= 1'b0;
         len_next_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         out_idx_ff   <= '0;
         rnd_ff       <= '0;
         for (int i = 0; i < 16; i++) blk_ff[i] <= '0;
      end else begin
         out_valid_ff <= out_load || (out_valid_ff && rsp_stall);
         unique case (state_ff)
            ST_IDLE: begin
               if (cmd_valid) begin
                  pend_end_ff <= cmd_data.is_end;
                  if (cmd_data.has_byte) begin
                     blk_ff[fill_ff[5:2]] <= blk_ff[fill_ff[5:2]]
                        | (32'(cmd_data.data_byte) << (8 * (3 - fill_ff[1:0])));
                     fill_ff <= fill_ff + 6'd1;
                     len_ff  <= len_ff + 61'd1;
                  end
                  if (cmd_data.has_byte && fill_ff == 6'd63) begin
                     v_ff     <= h_ff;
                     rnd_ff   <= '0;
                     state_ff <= ST_ROUND;
                  end else if (cmd_data.is_end) begin
                     state_ff <= ST_PAD;
                  end
               end
            end
            ST_ROUND: begin
               v_ff <= {v_ff[6:4], v_ff[3] + t1, v_ff[2:0], t1 + t2};
               if (rnd_ff >= 6'd16) begin
                  for (int i = 0; i < 15; i++) blk_ff[i] <= blk_ff[i+1];
                  blk_ff[15] <= w_new;
               end else if (rnd_ff == 6'd15) begin
                  for (int i = 0; i < 15; i++) blk_ff[i] <= blk_ff[i];
               end
               rnd_ff   <= rnd_ff + 6'd1;
               state_ff <= state_in;
            end
            ST_FIN: begin
               for (int i = 0; i < 8; i++) h_ff[i] <= h_ff[i] + v_ff[i];
               for (int i = 0; i < 16; i++) blk_ff[i] <= '0;
               if (second_ff) begin
                  second_ff  <= 1'b0;
                  out_idx_ff <= '0;
                  state_ff   <= ST_OUT;
               end else if (pend_end_ff || len_next_ff) begin
                  len_next_ff <= 1'b0;
                  state_ff    <= ST_PAD;
               end else begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_PAD: begin
               // pad byte goes in only once; the length block may follow a spill block
               if (!pend_end_ff) begin
                  blk_ff[14] <= bits[63:32];
                  blk_ff[15] <= bits[31:0];
                  second_ff  <= 1'b1;
                  v_ff       <= h_ff;
                  rnd_ff     <= '0;
                  state_ff   <= ST_ROUND;
               end else begin
                  pend_end_ff <= 1'b0;
                  blk_ff[fill_ff[5:2]] <= blk_ff[fill_ff[5:2]]
                     | (32'(sha_pkg::PadByte) << (8 * (3 - fill_ff[1:0])));
                  if (fill_ff >= sha_pkg::LenPos) begin
                     len_next_ff <= 1'b1;
                     v_ff        <= h_ff;
                     rnd_ff      <= '0;
                     state_ff    <= ST_ROUND;
                  end
               end
               fill_ff <= '0;
            end
            ST_OUT: begin
               if (out_load) begin
                  out_word_ff  <= h_ff[out_idx_ff];
                  out_widx_ff  <= out_idx_ff;
                  out_last_ff  <= (out_idx_ff == 3'd7);
                  out_idx_ff   <= out_idx_ff + 3'd1;
                  if (out_idx_ff == 3'd7) begin
                     h_ff     <= sha_pkg::InitHash;
                     len_ff   <= '0;
                     state_ff <= ST_IDLE;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end
endmodule

// File: rtl/sha256_stream_hasher.sv
// Top level of the byte-stream SHA-256 hasher
// channel | ports           | payload
// input   | req_valid/stall | data_byte, byte_valid, end_of_message
// output  | rsp_valid/stall | digest_word, word_index, last_word
// Bytes are taken only while the core is idle; a full block adds 64 rounds and the final addition.
// An end of message adds two padding steps and one or two compressions,
// then eight digest words, one a cycle while not stalled.
// Reset restores the initial hash; a queue decouples input from the core.
module sha256_stream_hasher #(
   parameter int QueueDepth = sha_pkg::QueueDepthDefault
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  sha_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output sha_pkg::rsp_type rsp_data
);
   logic             cmd_valid, cmd_take;
   sha_pkg::cmd_type cmd_data;

   sha_front #(.QueueDepth(QueueDepth)) u_front (
      .clock, .reset, .req_valid, .req_stall, .req_data,
      .cmd_valid, .cmd_take, .cmd_data);

   sha_back u_back (
      .clock, .reset, .cmd_valid, .cmd_take, .cmd_data,
      .rsp_valid, .rsp_stall, .rsp_data);
endmodule

// File: rtl/sha_checker.sv
// Port checker for the SHA-256 stream hasher, with its bind
`include "sha256_stream_hasher_defines.svh"
module sha_checker (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input sha_pkg::rsp_type rsp_data
);
   `SHA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)
   `SHA_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && rsp_stall, $stable(rsp_data))
   `SHA_ASSERT_IMPL(a_last, clock, reset, rsp_valid,
      rsp_data.last_word == (rsp_data.word_index == 3'd7))
   `SHA_ASSERT_NEXT(a_seq, clock, reset, rsp_valid && !rsp_stall && !rsp_data.last_word,
      !rsp_valid || rsp_data.word_index != 3'd0)
endmodule

bind sha256_stream_hasher sha_checker u_checker (
   .clock, .reset, .rsp_valid, .rsp_stall, .rsp_data);

// File: tb/sha256_digest_checker.sv
// Checker that predicts SHA-256 digest words from input transactions and compares them
`timescale 1ns / 1ps
module sha256_digest_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_stall,
   input  sha_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_stall,
   input  sha_pkg::rsp_type rsp_data,
   output int               error_count,
   output int               pending_words
);
   localparam sha_pkg::word_type [0:63] Kc = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
   localparam sha_pkg::word_type [0:7] Iv = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

   sha_pkg::word_type chain [0:7];
   logic [7:0]        blk [0:63];
   int                fill;
   logic [60:0]       msg_len;
   sha_pkg::rsp_type  digest_q[$];
   int                errors = 0;

   assign error_count = errors;

   function automatic sha_pkg::word_type ror(sha_pkg::word_type x, int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   task automatic compress();
      sha_pkg::word_type w [0:63];
      sha_pkg::word_type v [0:7];
      sha_pkg::word_type t1, t2;
      for (int i = 0; i < 16; i++)
         w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
      for (int i = 16; i < 64; i++)
         w[i] = (ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10)) + w[i-7]
              + (ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-16];
      for (int i = 0; i < 8; i++) v[i] = chain[i];
      for (int i = 0; i < 64; i++) begin
         t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
            + ((v[4] & v[5]) ^ (~v[4] & v[6])) + Kc[i] + w[i];
         t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
            + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
         v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
         v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) chain[i] += v[i];
   endtask

   task automatic absorb(sha_pkg::req_type r);
      logic [63:0]      bits;
      sha_pkg::rsp_type e;
      if (r.byte_valid) begin
         blk[fill] = r.data_byte;
         fill = (fill + 1) % 64;
         msg_len = msg_len + 1;
         if (fill == 0) compress();
      end
      if (r.end_of_message) begin
         bits = {msg_len, 3'b000};
         blk[fill] = sha_pkg::PadByte;
         for (int i = fill + 1; i < 64; i++) blk[i] = 8'h00;
         if (fill >= 56) begin
            compress();
            for (int i = 0; i < 64; i++) blk[i] = 8'h00;
         end
         for (int i = 0; i < 8; i++) blk[56+i] = bits[63-8*i -: 8];
         compress();
         for (int i = 0; i < 8; i++) begin
            e.digest_word = chain[i];
            e.word_index = 3'(i);
            e.last_word = (i == 7);
            digest_q.push_back(e);
         end
         for (int i = 0; i < 8; i++) chain[i] = Iv[i];
         fill = 0;
         msg_len = '0;
      end
   endtask

   initial begin
      for (int i = 0; i < 8; i++) chain[i] = Iv[i];
      fill = 0;
      msg_len = '0;
   end

   always @(posedge clock) begin
      sha_pkg::rsp_type e;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (digest_q.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("unexpected digest transaction %h", rsp_data);
            end else begin
               e = digest_q.pop_front();
               if (rsp_data.digest_word !== e.digest_word
                   || rsp_data.word_index !== e.word_index
                   || rsp_data.last_word !== e.last_word) begin
                  errors++;
                  if (errors <= 10)
                     $display("digest mismatch: exp %h/%0d/%b got %h/%0d/%b",
                        e.digest_word, e.word_index, e.last_word,
                        rsp_data.digest_word, rsp_data.word_index,
                        rsp_data.last_word);
               end
            end
         end
         if (req_valid && !req_stall) absorb(req_data);
      end
      pending_words = digest_q.size();
   end
endmodule

// File: tb/sha256_stream_hasher_tb.sv
// Top of the SHA-256 stream hasher testbench: stimulus, stalls and verdict
`timescale 1ns / 1ps
module sha256_stream_hasher_tb;
   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   sha_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   sha_pkg::rsp_type rsp_data;
   int               error_count, pending_words;
   bit               calm = 1'b0;
   bit               hold_off = 1'b0;
   sha_pkg::req_type stim_q[$];

   sha256_stream_hasher dut (.*);
   sha256_digest_checker checker_i (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   initial begin
      #20ms;
      $display("sha256_stream_hasher regression: fail");
      $finish;
   end

   always @(posedge clock) begin
      if (reset) rsp_stall <= 1'b0;
      else rsp_stall <= hold_off || (!calm && $urandom_range(99) < 32);
   end

   function automatic sha_pkg::req_type mk(logic [7:0] b, logic v, logic e);
      sha_pkg::req_type r;
      r.data_byte = b; r.byte_valid = v; r.end_of_message = e;
      return r;
   endfunction

   task automatic add_msg(int n, bit last_with_byte);
      for (int i = 0; i < n - 1; i++) begin
         if ($urandom_range(9) == 0) stim_q.push_back(mk(8'($urandom), 1'b0, 1'b0));
         stim_q.push_back(mk(8'($urandom), 1'b1, 1'b0));
      end
      if (last_with_byte && n > 0) stim_q.push_back(mk(8'($urandom), 1'b1, 1'b1));
      else begin
         if (n > 0) stim_q.push_back(mk(8'($urandom), 1'b1, 1'b0));
         stim_q.push_back(mk(8'($urandom), 1'b0, 1'b1));
      end
   endtask

   initial begin
      int n;
      // directed: empty, extremes, idle item, boundary lengths
      stim_q.push_back(mk(8'hff, 1'b0, 1'b1));
      stim_q.push_back(mk(8'h00, 1'b0, 1'b0));
      stim_q.push_back(mk(8'hff, 1'b1, 1'b1));
      stim_q.push_back(mk(8'h00, 1'b1, 1'b0));
      stim_q.push_back(mk(8'h00, 1'b0, 1'b1));
      add_msg(3, 1'b1);
      add_msg(1, 1'b0);
      add_msg(0, 1'b0);
      add_msg(55, 1'b1);
      add_msg(56, 1'b1);
      add_msg(64, 1'b0);
      while (stim_q.size() < 208) begin
         case ($urandom_range(2))
            0: add_msg($urandom_range(0, 8), 1'($urandom_range(1)));
            1: add_msg($urandom_range(9, 20), 1'($urandom_range(1)));
            default: stim_q.push_back(mk(8'($urandom), 1'($urandom), 1'b0));
         endcase
      end
      stim_q.push_back(mk(8'h5a, 1'b0, 1'b1));

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      n = 0;
      foreach (stim_q[i]) begin
         while (!calm && $urandom_range(99) < 32) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
         req_valid <= 1'b1;
         req_data <= stim_q[i];
         n++;
         if (n == 100) calm = 1'b1;
         if (n == 170) calm = 1'b0;
         if (n == 60) fork begin
            hold_off = 1'b1;
            repeat (400) @(posedge clock);
            hold_off = 1'b0;
         end join_none
         do @(posedge clock); while (req_stall);
      end
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_words != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (error_count == 0 && pending_words == 0)
         $display("sha256_stream_hasher regression: pass");
      else
         $display("sha256_stream_hasher regression: fail");
      $finish;
   end
endmodule

// File: filelist.f
+incdir+rtl
rtl/sha_pkg.sv
rtl/sha_front.sv
rtl/sha_back.sv
rtl/sha256_stream_hasher.sv
rtl/sha_checker.sv
tb/sha256_digest_checker.sv
tb/sha256_stream_hasher_tb.sv
